@@ design/v3n_pkg.sv @@
package v3n_pkg;
   localparam int OUT_WIDTH = 18;
   localparam int SUM_WIDTH = 64;
   localparam int ROOT_WIDTH = 32;
endpackage

@@ design/v3n_front.sv @@
module v3n_front import v3n_pkg::*; #(
   parameter int SCALAR_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [SCALAR_WIDTH-1:0] in_x,
   input  logic [SCALAR_WIDTH-1:0] in_y,
   input  logic [SCALAR_WIDTH-1:0] in_z,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [3*SCALAR_WIDTH-1:0] out_mag,
   output logic [2:0]              out_neg,
   output logic [SUM_WIDTH-1:0]    out_sum
);
   logic                      s1_valid_ff, s2_valid_ff;
   logic [3*SCALAR_WIDTH-1:0] s1_mag_ff, s2_mag_ff;
   logic [2:0]                s1_neg_ff, s2_neg_ff;
   logic [SUM_WIDTH-1:0]      sq_ff [3];
   logic [SUM_WIDTH-1:0]      s2_sum_ff;
   logic                      adv;

   function automatic logic [SCALAR_WIDTH-1:0] mag_of(input logic [SCALAR_WIDTH-1:0] v);
      mag_of = v[SCALAR_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign adv = !s2_valid_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = s2_valid_ff;
   assign out_mag = s2_mag_ff;
   assign out_neg = s2_neg_ff;
   assign out_sum = s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s1_mag_ff <= {mag_of(in_z), mag_of(in_y), mag_of(in_x)};
         s1_neg_ff <= {in_z[SCALAR_WIDTH-1], in_y[SCALAR_WIDTH-1], in_x[SCALAR_WIDTH-1]};
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SUM_WIDTH'(mag_of(i == 0 ? in_x : (i == 1 ? in_y : in_z)))
                        * SUM_WIDTH'(mag_of(i == 0 ? in_x : (i == 1 ? in_y : in_z)));
         end
         s2_mag_ff <= s1_mag_ff;
         s2_neg_ff <= s1_neg_ff;
         s2_sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end
endmodule

@@ design/v3n_back.sv @@
module v3n_back import v3n_pkg::*; #(
   parameter int SCALAR_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [3*SCALAR_WIDTH-1:0] in_mag,
   input  logic [2:0]                in_neg,
   input  logic [SUM_WIDTH-1:0]      in_sum,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [3*OUT_WIDTH-1:0]    out_unit
);
   localparam int RS = ROOT_WIDTH;
   localparam int NW = SCALAR_WIDTH + FRAC_BITS;
   localparam int DEPTH = RS + NW + 1;

   logic adv;
   logic                      v_ff   [DEPTH];
   logic [SUM_WIDTH-1:0]      rem_ff [DEPTH];
   logic [RS-1:0]             root_ff[DEPTH];
   logic                      zero_ff[DEPTH];
   logic [3*SCALAR_WIDTH-1:0] mag_ff [DEPTH];
   logic [2:0]                neg_ff [DEPTH];
   logic [NW-1:0]             q_ff   [DEPTH][3];
   logic [NW:0]               r_ff   [DEPTH][3];

   assign adv = !v_ff[DEPTH-1] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[DEPTH-1];

   // Stages 1..RS: one root bit each (restoring digit method).
   // Stages RS+1..RS+NW: one quotient bit per component, three dividers in lockstep.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < DEPTH; s++) v_ff[s] <= v_ff[s-1];
      end
      if (adv) begin
         rem_ff[0]  <= in_sum;
         root_ff[0] <= '0;
         zero_ff[0] <= (in_sum == '0);
         mag_ff[0]  <= in_mag;
         neg_ff[0]  <= in_neg;
         for (int c = 0; c < 3; c++) begin
            q_ff[0][c] <= '0;
            r_ff[0][c] <= '0;
         end
         for (int s = 1; s < DEPTH; s++) begin
            zero_ff[s] <= zero_ff[s-1];
            mag_ff[s]  <= mag_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            rem_ff[s]  <= rem_ff[s-1];
         end
         for (int s = 1; s <= RS; s++) begin
            logic [RS-1:0] trial;
            logic [SUM_WIDTH-1:0] sq;
            trial = root_ff[s-1] | (RS'(1) << (RS - s));
            sq = SUM_WIDTH'(trial) * SUM_WIDTH'(trial);
            root_ff[s] <= (sq <= rem_ff[s-1]) ? trial : root_ff[s-1];
            for (int c = 0; c < 3; c++) begin
               q_ff[s][c] <= '0;
               r_ff[s][c] <= '0;
            end
         end
         for (int s = RS + 1; s < DEPTH; s++) begin
            logic [NW:0] rr;
            logic [NW-1:0] num;
            root_ff[s] <= root_ff[s-1];
            for (int c = 0; c < 3; c++) begin
               num = NW'(mag_ff[s-1][c*SCALAR_WIDTH +: SCALAR_WIDTH]) << FRAC_BITS;
               rr = {r_ff[s-1][c][NW-1:0], num[NW + RS - s]};
               if (rr >= (NW+1)'(root_ff[s-1])) begin
                  r_ff[s][c] <= rr - (NW+1)'(root_ff[s-1]);
                  q_ff[s][c] <= q_ff[s-1][c] | (NW'(1) << (NW + RS - s));
               end else begin
                  r_ff[s][c] <= rr;
                  q_ff[s][c] <= q_ff[s-1][c];
               end
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [NW-1:0] q;
         q = neg_ff[DEPTH-1][c] ? (~q_ff[DEPTH-1][c] + 1'b1) : q_ff[DEPTH-1][c];
         if (zero_ff[DEPTH-1])
            out_unit[c*OUT_WIDTH +: OUT_WIDTH] = (c == 0) ? OUT_WIDTH'(64'd1 << FRAC_BITS) : '0;
         else
            out_unit[c*OUT_WIDTH +: OUT_WIDTH] = q[OUT_WIDTH-1:0];
      end
   end
endmodule

@@ design/v3n_queue.sv @@
module v3n_queue import v3n_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

@@ design/vector3_normalise.sv @@
// Normalizes one signed fixed-point 3-vector per cycle to a unit vector with
// 18-bit signed components; an all-zero vector gives (1.0, 0, 0). Throughput is one
// item per cycle while the output is not stalled. An accepted item passes through
// two front stages, the two-entry queue, an input stage, one stage per root bit and
// one stage per quotient bit. Both sides stall independently.
module vector3_normalise import v3n_pkg::*; #(
   parameter int SCALAR_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // in_x, in_y, in_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // unit_x, unit_y, unit_z, zero fill
);
   localparam int QW = 3*SCALAR_WIDTH + 3 + SUM_WIDTH;
   logic fv, fr, qv, qr;
   logic [3*SCALAR_WIDTH-1:0] fmag;
   logic [2:0] fneg;
   logic [SUM_WIDTH-1:0] fsum;
   logic [QW-1:0] qd;
   logic [3*OUT_WIDTH-1:0] unit;

   v3n_front #(.SCALAR_WIDTH(SCALAR_WIDTH)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_x(req_tdata[SCALAR_WIDTH-1:0]), .in_y(req_tdata[32 +: SCALAR_WIDTH]),
      .in_z(req_tdata[64 +: SCALAR_WIDTH]),
      .out_valid(fv), .out_ready(fr), .out_mag(fmag), .out_neg(fneg), .out_sum(fsum));

   v3n_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .in_valid(fv), .in_ready(fr), .in_data({fsum, fneg, fmag}),
      .out_valid(qv), .out_ready(qr), .out_data(qd));

   v3n_back #(.SCALAR_WIDTH(SCALAR_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(qv), .in_ready(qr),
      .in_mag(qd[3*SCALAR_WIDTH-1:0]), .in_neg(qd[3*SCALAR_WIDTH +: 3]),
      .in_sum(qd[3*SCALAR_WIDTH+3 +: SUM_WIDTH]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_unit(unit));

   assign rsp_tdata = {2'b00, unit};
endmodule

@@ design/vector3_normalise_checker.sv @@
module vector3_normalise_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:54] == 2'b00)
      else $error("fill bits set");
   a_zero: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid}))
      else $error("handshake unknown");
endmodule

bind vector3_normalise vector3_normalise_checker u_checker (.*);
